// ===== hw/rtl/deq_pkg.sv =====
package deq_pkg;

  // Field widths of the request and result items that do not follow the depth.
  localparam int REQ_W    = 3;
  localparam int INDEX_W  = 8;
  localparam int STATUS_W = 2;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_GET        = 3'd4;
  localparam logic [REQ_W-1:0] REQ_SIZE       = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_OUT_RANGE = 2'd3;

  // Commands broadcast to every cell of the chain.
  typedef struct packed {
    logic shift_r;  // push front: every word moves one cell toward the back
    logic shift_l;  // pop front: every word moves one cell toward the front
    logic write;    // push back: the selected cell takes the pushed word
    logic load;     // the selected cell copies its word into the read chain
    logic move;     // the read chain moves one cell toward the front
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/deq_cell.sv =====
module deq_cell
  import deq_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic                  wr_sel,
  input  logic                  rd_sel,
  input  logic [DATA_WIDTH-1:0] value,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic [DATA_WIDTH-1:0] right_rd,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] rd
);

  // Held word: shifts with its neighbors or takes a pushed word.
  always_ff @(posedge clk) begin
    if (ctrl.shift_r) begin
      data <= left_data;
    end else if (ctrl.shift_l) begin
      data <= right_data;
    end else if (ctrl.write && wr_sel) begin
      data <= value;
    end
  end

  // Read chain stage: the selected cell injects its word, then it walks to the front.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rd <= rd_sel ? data : '0;
    end else if (ctrl.move) begin
      rd <= right_rd;
    end
  end

endmodule

// ===== hw/rtl/double_ended_queue_top.sv =====
// Double-ended queue built from a row of DEPTH storage cells, cell 0 holding the
// front word. Requests arrive on the s_* stream channel, one result per request
// leaves on the m_* stream channel through an output register.
// Push front and pop front shift the whole row by one cell at once;
// push back writes the cell just past the last held word.
// Get and pop back copy the wanted cell into a second chain of read registers,
// which carries the word one cell per cycle toward cell 0.
// Pushes, pop front, size and refused requests go from the input transfer
// through the done state into the output register; get and pop back pass the
// scan state first, while the read chain walks the word to cell 0.
// One request is in work at a time; the next is taken once the previous result
// has entered the result stage.
// Reset empties the queue (front at cell 0, count zero) and drops any result
// not yet transferred. The stored words need no reset; only held cells are read.
// When the receiver stalls, the finished result waits in the output register,
// at most one more request is worked off, and then s_tready stays low.
module double_ended_queue_top
  import deq_pkg::*;
#(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32,
  localparam int CNT_W     = $clog2(DEPTH + 1),
  localparam int IN_W      = ((REQ_W + DATA_WIDTH + INDEX_W + 7) / 8) * 8,
  localparam int OUT_W     = ((DATA_WIDTH + CNT_W + STATUS_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // req_type, value, index, zero fill
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // data, count, status, zero fill
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]            state;
  logic [CNT_W-1:0]      count;
  logic [PTR_W-1:0]      steps;
  logic [DATA_WIDTH-1:0] res_data;
  logic [STATUS_W-1:0]   res_status;

  logic [REQ_W-1:0]      req_type;
  logic [DATA_WIDTH-1:0] value;
  logic [INDEX_W-1:0]    index;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic                  idx_bad;

  cell_ctrl_t            ctrl;
  logic [PTR_W-1:0]      wr_pos;
  logic [PTR_W-1:0]      rd_pos;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_rd   [DEPTH];

  // Unpack the request.
  assign req_type = s_tdata[REQ_W-1:0];
  assign value    = s_tdata[REQ_W +: DATA_WIDTH];
  assign index    = s_tdata[REQ_W + DATA_WIDTH +: INDEX_W];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign idx_bad  = (CMP_W'(index) >= CMP_W'(count));

  assign wr_pos = count[PTR_W-1:0];
  assign rd_pos = (req_type == REQ_GET) ? PTR_W'(index) : PTR_W'(count - CNT_W'(1));

  // Commands for the cell row.
  always_comb begin
    ctrl = '0;
    if (accept) begin
      unique case (req_type)
        REQ_PUSH_BACK:  ctrl.write   = !full;
        REQ_PUSH_FRONT: ctrl.shift_r = !full;
        REQ_POP_FRONT:  ctrl.shift_l = !empty;
        REQ_POP_BACK:   ctrl.load    = !empty;
        REQ_GET:        ctrl.load    = !idx_bad;
        default:        ctrl         = '0;
      endcase
    end else if (state == S_SCAN && steps != '0) begin
      ctrl.move = 1'b1;
    end
  end

  // Row of storage cells, each linked to the neighbors it has.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic [DATA_WIDTH-1:0] right_data;
    logic [DATA_WIDTH-1:0] right_rd;

    if (k == 0) begin : g_first
      assign left_data = value;
    end else begin : g_mid
      assign left_data = cell_data[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign right_data = '0;
      assign right_rd   = '0;
    end else begin : g_inner
      assign right_data = cell_data[k+1];
      assign right_rd   = cell_rd[k+1];
    end

    deq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .wr_sel     (wr_pos == PTR_W'(k)),
      .rd_sel     (rd_pos == PTR_W'(k)),
      .value      (value),
      .left_data  (left_data),
      .right_data (right_data),
      .right_rd   (right_rd),
      .data       (cell_data[k]),
      .rd         (cell_rd[k])
    );
  end

  // Sequencer and element count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_DONE;
            unique case (req_type)
              REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
                if (!full) begin
                  count <= count + CNT_W'(1);
                end
              end
              REQ_POP_FRONT: begin
                if (!empty) begin
                  count <= count - CNT_W'(1);
                end
              end
              REQ_POP_BACK: begin
                if (!empty) begin
                  count <= count - CNT_W'(1);
                  state <= S_SCAN;
                end
              end
              REQ_GET: begin
                if (!idx_bad) begin
                  state <= S_SCAN;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (steps == '0) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result word, status and read chain step counter.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_data   <= '0;
      res_status <= STAT_OK;
      steps      <= rd_pos;
      unique case (req_type)
        REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
          if (full) begin
            res_status <= STAT_FULL;
          end
        end
        REQ_POP_FRONT: begin
          if (empty) begin
            res_status <= STAT_EMPTY;
          end else begin
            res_data <= cell_data[0];
          end
        end
        REQ_POP_BACK: begin
          if (empty) begin
            res_status <= STAT_EMPTY;
          end
        end
        REQ_GET: begin
          if (idx_bad) begin
            res_status <= STAT_OUT_RANGE;
          end
        end
        default: begin
          res_status <= STAT_OK;
        end
      endcase
    end else if (state == S_SCAN) begin
      if (steps == '0) begin
        res_data <= cell_rd[0];
      end else begin
        steps <= steps - PTR_W'(1);
      end
    end
  end

  // Output register toward the receiver.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= OUT_W'({res_status, count, res_data});
    end
  end

endmodule
